// ----- rtl/core/recl_pkg.sv -----
// Shared types, codes and constants for the reference-counted entry cache.
package recl_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int FUNC_W      = 3;
  localparam int DEV_W       = 16;
  localparam int NUM_W       = 32;
  localparam int SLOT_IN_W   = 6;
  localparam int CNT_W       = 16;
  localparam int REFS_W      = 16;
  localparam int STAT_W      = 3;
  localparam int SLOT_MAX_W  = 10;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  localparam logic [FUNC_W-1:0] FN_GET  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DUP  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_BULK = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_EXEC,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_REMOVE,
    LOP_HEAD,
    LOP_TAIL
  } list_op_t;

  // Command broadcast to every cell of the unused-slot list
  typedef struct packed {
    list_op_t                op;
    logic [SLOT_MAX_W-1:0]   value;
  } list_cmd_t;

  // Write broadcast to every entry cell
  typedef struct packed {
    logic                    we;
    logic [SLOT_MAX_W-1:0]   idx;
    logic                    load;
    logic                    clear;
    logic [REFS_W-1:0]       refs;
    logic [DEV_W-1:0]        dev;
    logic [NUM_W-1:0]        num;
  } entry_wr_t;

endpackage

// ----- rtl/core/recl_if.sv -----
// Request and response channel interfaces of the entry cache.
interface recl_req_if;
  logic                            valid;
  logic                            ready;
  logic [recl_pkg::FUNC_W-1:0]     func;
  logic [recl_pkg::DEV_W-1:0]      device;
  logic [recl_pkg::NUM_W-1:0]      object_number;
  logic [recl_pkg::SLOT_IN_W-1:0]  slot;
  logic [recl_pkg::CNT_W-1:0]      release_count;
  logic                            no_links;

  modport source (output valid, func, device, object_number, slot, release_count, no_links,
                  input ready);
  modport sink (input valid, func, device, object_number, slot, release_count, no_links,
                output ready);
endinterface

interface recl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [recl_pkg::STAT_W-1:0]     status;
  logic [recl_pkg::SLOT_IN_W-1:0]  result_slot;
  logic                            was_hit;
  logic [recl_pkg::REFS_W-1:0]     refs_now;
  logic                            truncate_request;
  logic                            number_freed;

  modport source (output valid, status, result_slot, was_hit, refs_now, truncate_request,
                  number_freed, input ready);
  modport sink (input valid, status, result_slot, was_hit, refs_now, truncate_request,
                number_freed, output ready);
endinterface

// ----- rtl/core/recl_entry_cell.sv -----
// One table slot: key, valid flag and reference count, with its own match logic.
module recl_entry_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  recl_pkg::entry_wr_t         wr,
  input  logic [recl_pkg::DEV_W-1:0]  key_dev,
  input  logic [recl_pkg::NUM_W-1:0]  key_num,
  output logic                        match_get,
  output logic                        match_num,
  output logic [recl_pkg::REFS_W-1:0] refs,
  output logic [recl_pkg::NUM_W-1:0]  number
);
  import recl_pkg::*;

  logic              valid_r, valid_nxt;
  logic [REFS_W-1:0] refs_r, refs_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic              sel;

  // Compare against the pending request key
  assign match_get = valid_r && (num_r == key_num) && (dev_r == key_dev);
  assign match_num = valid_r && (refs_r != '0) && (num_r == key_num);
  assign refs      = refs_r;
  assign number    = num_r;

  // Apply the broadcast write when it targets this slot
  assign sel = wr.we && (wr.idx == SLOT_MAX_W'(IDX));

  always_comb begin
    valid_nxt = valid_r;
    refs_nxt  = refs_r;
    dev_nxt   = dev_r;
    num_nxt   = num_r;
    if (sel) begin
      refs_nxt = wr.refs;
      if (wr.load) begin
        valid_nxt = 1'b1;
        dev_nxt   = wr.dev;
        num_nxt   = wr.num;
      end else if (wr.clear) begin
        valid_nxt = 1'b0;
        num_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      refs_r  <= '0;
      dev_r   <= '0;
      num_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      refs_r  <= refs_nxt;
      dev_r   <= dev_nxt;
      num_r   <= num_nxt;
    end
  end

endmodule

// ----- rtl/core/recl_list_cell.sv -----
// One position of the ordered unused-slot list; shifts with its neighbors.
module recl_list_cell #(
  parameter int ENTRIES = recl_pkg::ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  recl_pkg::list_cmd_t                  cmd,
  input  logic [$clog2(ENTRIES+1)-1:0]         len,
  input  logic [$clog2(ENTRIES)-1:0]           left_val,
  input  logic [$clog2(ENTRIES)-1:0]           right_val,
  input  logic                                 seen_in,
  output logic [$clog2(ENTRIES)-1:0]           val,
  output logic                                 seen_out
);
  import recl_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  logic [SW-1:0] val_r, val_nxt;
  logic          in_list;
  logic          hit;

  assign in_list  = LW'(IDX) < len;
  assign hit      = (cmd.op == LOP_REMOVE) && in_list && (val_r == SW'(cmd.value));
  assign seen_out = seen_in || hit;
  assign val      = val_r;

  // Close the gap on removal, shift right on head insert, append at the tail
  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      LOP_REMOVE: if (seen_out) val_nxt = right_val;
      LOP_HEAD:   val_nxt = left_val;
      LOP_TAIL:   if (LW'(IDX) == len) val_nxt = SW'(cmd.value);
      LOP_NONE:   val_nxt = val_r;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= SW'(ENTRIES - 1 - IDX);
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

// ----- rtl/core/refcounted_entry_cache_lru.sv -----
// Reference-counted entry cache with an LRU-ordered unused list: each request passes through
// the match, pick and execute steps and the result register before the result handshake,
// and the request port reopens only after that handshake, so one request is in flight at a
// time; a new request waits until the previous result is taken, so output stalls hold it off.
// Lookup is a fully associative compare in a row of slot cells; the unused list is a
// row of cells that shift by one position on removal or head insertion.
// Get hits or claims the head slot of the unused list, put and bulk release drop references,
// find and dup look up and add. Faults report a status and change nothing.
module refcounted_entry_cache_lru #(
  parameter int ENTRIES = recl_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  recl_req_if.sink          in_ch,
  recl_rsp_if.source        out_ch
);
  import recl_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0]    func_r;
  logic [DEV_W-1:0]     dev_r;
  logic [NUM_W-1:0]     numb_r;
  logic [SLOT_IN_W-1:0] slot_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 nolink_r;

  logic [ENTRIES-1:0]   mg_r, mn_r, mg_vec, mn_vec;
  logic [SW-1:0]        sel_r, sel_nxt;
  logic                 found_r, found_nxt;
  logic [LW-1:0]        len_r, len_nxt;

  logic [STAT_W-1:0]    o_status_r, o_status_nxt;
  logic [SLOT_IN_W-1:0] o_slot_r, o_slot_nxt;
  logic                 o_hit_r, o_hit_nxt;
  logic [REFS_W-1:0]    o_refs_r, o_refs_nxt;
  logic                 o_trunc_r, o_trunc_nxt;
  logic                 o_freed_r, o_freed_nxt;

  entry_wr_t            wr;
  list_cmd_t            lcmd;

  logic [REFS_W-1:0]    refs_a [ENTRIES];
  logic [NUM_W-1:0]     num_a  [ENTRIES];
  logic [SW-1:0]        lv     [ENTRIES];
  logic                 seen   [ENTRIES];

  logic [SW-1:0]        pick_get, pick_num;
  logic                 in_acc;
  logic                 in_range;
  logic [REFS_W-1:0]    cur_refs;
  logic [NUM_W-1:0]     cur_num;
  logic                 do_rel;
  logic [REFS_W-1:0]    rel_refs;

  // Row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    recl_entry_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr),
      .key_dev  (dev_r),
      .key_num  (numb_r),
      .match_get(mg_vec[i]),
      .match_num(mn_vec[i]),
      .refs     (refs_a[i]),
      .number   (num_a[i])
    );
  end

  // Row of unused-list cells; cell 0 takes the head value from the command
  for (genvar i = 0; i < ENTRIES; i++) begin : g_list
    recl_list_cell #(.ENTRIES(ENTRIES), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (lcmd),
      .len      (len_r),
      .left_val ((i == 0) ? SW'(lcmd.value) : lv[(i == 0) ? 0 : i-1]),
      .right_val(lv[(i == ENTRIES-1) ? i : i+1]),
      .seen_in  ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i-1]),
      .val      (lv[i]),
      .seen_out (seen[i])
    );
  end

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status           = o_status_r;
  assign out_ch.result_slot      = o_slot_r;
  assign out_ch.was_hit          = o_hit_r;
  assign out_ch.refs_now         = o_refs_r;
  assign out_ch.truncate_request = o_trunc_r;
  assign out_ch.number_freed     = o_freed_r;

  // Lowest matching slot wins
  always_comb begin
    pick_get = '0;
    pick_num = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (mg_r[i]) pick_get = SW'(i);
      if (mn_r[i]) pick_num = SW'(i);
    end
  end

  assign in_range = 32'(slot_r) < 32'(ENTRIES);
  assign cur_refs = refs_a[sel_r];
  assign cur_num  = num_a[sel_r];

  // Sequence one request and work out its effect in the execute step
  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    found_nxt    = found_r;
    len_nxt      = len_r;
    o_status_nxt = o_status_r;
    o_slot_nxt   = o_slot_r;
    o_hit_nxt    = o_hit_r;
    o_refs_nxt   = o_refs_r;
    o_trunc_nxt  = o_trunc_r;
    o_freed_nxt  = o_freed_r;
    wr           = '0;
    lcmd         = '0;
    lcmd.op      = LOP_NONE;
    do_rel       = 1'b0;
    rel_refs     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = S_EXEC;
        priority if (func_r == FN_GET) begin
          found_nxt = |mg_r;
          sel_nxt   = (|mg_r) ? pick_get : lv[0];
        end else if (func_r == FN_FIND || func_r == FN_BULK) begin
          found_nxt = |mn_r;
          sel_nxt   = pick_num;
        end else begin
          found_nxt = 1'b0;
          sel_nxt   = SW'(slot_r);
        end
      end
      S_EXEC: begin
        state_nxt    = S_OUT;
        o_status_nxt = ST_OK;
        o_slot_nxt   = '0;
        o_hit_nxt    = 1'b0;
        o_refs_nxt   = '0;
        o_trunc_nxt  = 1'b0;
        o_freed_nxt  = 1'b0;
        lcmd.value   = SLOT_MAX_W'(sel_r);
        wr.idx       = SLOT_MAX_W'(sel_r);
        wr.dev       = dev_r;
        wr.num       = numb_r;
        unique case (func_r)
          FN_GET: begin
            if (found_r) begin
              o_slot_nxt = SLOT_IN_W'(sel_r);
              if (cur_refs == REFS_MAX) begin
                o_status_nxt = ST_OVERFLOW;
                o_refs_nxt   = cur_refs;
              end else begin
                if (cur_refs == '0) lcmd.op = LOP_REMOVE;
                wr.we      = 1'b1;
                wr.refs    = cur_refs + 1'b1;
                o_hit_nxt  = 1'b1;
                o_refs_nxt = cur_refs + 1'b1;
              end
            end else if (len_r == '0) begin
              o_status_nxt = ST_FULL;
            end else begin
              lcmd.op    = LOP_REMOVE;
              wr.we      = 1'b1;
              wr.load    = 1'b1;
              wr.refs    = REFS_W'(1);
              o_slot_nxt = SLOT_IN_W'(sel_r);
              o_refs_nxt = REFS_W'(1);
            end
          end
          FN_PUT: begin
            o_slot_nxt = slot_r;
            if (!in_range) begin
              o_status_nxt = ST_NOT_FOUND;
            end else if (cur_refs == '0) begin
              o_status_nxt = ST_UNDERFLOW;
            end else begin
              do_rel   = 1'b1;
              rel_refs = cur_refs - 1'b1;
            end
          end
          FN_FIND: begin
            if (!found_r) begin
              o_status_nxt = ST_NOT_FOUND;
            end else begin
              o_slot_nxt = SLOT_IN_W'(sel_r);
              o_refs_nxt = cur_refs;
            end
          end
          FN_DUP: begin
            o_slot_nxt = slot_r;
            if (!in_range || cur_refs == '0) begin
              o_status_nxt = ST_NOT_FOUND;
            end else if (cur_refs == REFS_MAX) begin
              o_status_nxt = ST_OVERFLOW;
              o_refs_nxt   = cur_refs;
            end else begin
              wr.we      = 1'b1;
              wr.refs    = cur_refs + 1'b1;
              o_refs_nxt = cur_refs + 1'b1;
            end
          end
          FN_BULK: begin
            if (!found_r) begin
              o_status_nxt = ST_NOT_FOUND;
            end else begin
              o_slot_nxt = SLOT_IN_W'(sel_r);
              o_refs_nxt = cur_refs;
              if (cnt_r == '0 || cnt_r > cur_refs) begin
                o_status_nxt = ST_BAD_COUNT;
              end else begin
                do_rel   = 1'b1;
                rel_refs = cur_refs - cnt_r;
              end
            end
          end
          default: begin
            o_status_nxt = ST_NOT_FOUND;
          end
        endcase

        // Drop references; at zero, unlinked entries go to the head, others to the tail
        if (do_rel) begin
          wr.we      = 1'b1;
          wr.refs    = rel_refs;
          o_refs_nxt = rel_refs;
          if (rel_refs == '0) begin
            o_trunc_nxt = 1'b1;
            if (nolink_r) begin
              o_freed_nxt = (cur_num >= 32'd1) && (cur_num < 32'(ENTRIES));
              wr.clear    = 1'b1;
              lcmd.op     = LOP_HEAD;
            end else begin
              lcmd.op     = LOP_TAIL;
            end
          end
        end

        priority case (lcmd.op)
          LOP_REMOVE:        len_nxt = len_r - 1'b1;
          LOP_HEAD, LOP_TAIL: len_nxt = len_r + 1'b1;
          default:           len_nxt = len_r;
        endcase
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= LW'(ENTRIES);
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  // Capture the request, the match vectors and the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_ch.func;
      dev_r    <= in_ch.device;
      numb_r   <= in_ch.object_number;
      slot_r   <= in_ch.slot;
      cnt_r    <= in_ch.release_count;
      nolink_r <= in_ch.no_links;
    end
    if (state_r == S_MATCH) begin
      mg_r <= mg_vec;
      mn_r <= mn_vec;
    end
    sel_r      <= sel_nxt;
    found_r    <= found_nxt;
    o_status_r <= o_status_nxt;
    o_slot_r   <= o_slot_nxt;
    o_hit_r    <= o_hit_nxt;
    o_refs_r   <= o_refs_nxt;
    o_trunc_r  <= o_trunc_nxt;
    o_freed_r  <= o_freed_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(ENTRIES))
    else $error("unused list longer than the table");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_MATCH)
    else $error("accepted transaction did not start a lookup");

  a_remove_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && lcmd.op == LOP_REMOVE) |=> len_r == $past(len_r) - 1'b1)
    else $error("list removal did not shorten the list");

endmodule
